[sv/lpt_pkg.sv]
// Shared types and constants of the LPT job scheduler.
`default_nettype none
package lpt_pkg;
  localparam int MAX_JOBS     = 64;
  localparam int MAX_MACHINES = 16;
  localparam int DUR_W        = 16;
  localparam int JOB_W        = 6;
  localparam int MACH_W       = 4;
  localparam int CNT_W        = 7;
  localparam int MC_W         = 5;
  localparam int K_W          = 5;
  localparam int LOAD_W       = DUR_W + JOB_W;

  typedef struct packed {
    logic             valid;
    logic [DUR_W-1:0] dur;
    logic [JOB_W-1:0] idx;
  } cell_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_SHIFT,
    OP_CLEAR
  } chain_op_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCHED,
    ST_EMIT_RD,
    ST_EMIT_WT
  } state_e;
endpackage
`default_nettype wire

[sv/lpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lpt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[sv/lpt_cell.sv]
// One cell of the sorted job chain: holds one job and inserts or shifts.
`default_nettype none
module lpt_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lpt_pkg::chain_op_e op_i,
  input  wire lpt_pkg::cell_t    new_i,
  input  wire lpt_pkg::cell_t    left_i,
  input  wire logic              left_first_i,
  input  wire lpt_pkg::cell_t    right_i,
  output lpt_pkg::cell_t         cur_o,
  output logic                   first_o
);
  lpt_pkg::cell_t cur_q, cur_d;

  // A new job is always younger than any stored one, so a tie puts it first.
  assign first_o = !cur_q.valid || (new_i.dur >= cur_q.dur);
  assign cur_o   = cur_q;

  always_comb begin
    cur_d = cur_q;
    case (op_i)
      lpt_pkg::OP_INS: begin
        if (first_o) begin
          cur_d = left_first_i ? left_i : new_i;
        end
      end
      lpt_pkg::OP_SHIFT: cur_d = right_i;
      lpt_pkg::OP_CLEAR: cur_d.valid = 1'b0;
      default: cur_d = cur_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end
endmodule
`default_nettype wire

[sv/lpt_job_scheduler.sv]
// Top level of the longest-processing-time-first job scheduler.
// Usage: jobs enter on the input channel (duration_i, last_job_i) one per
// cycle while in_stall_o is low. Each stored job is inserted into a sorted
// chain of cells at once. The job with last_job_i set closes the batch; the
// input then stalls while scheduling runs. Each job is taken from the chain
// head and assigned by a serial scan over the machine loads. Results then
// leave in arrival order through an output register, read from the
// assignment RAM in ST_EMIT_RD and registered in ST_EMIT_WT. The input
// channel reopens once the final result is in the output register. A stalled
// result holds its fields. Jobs beyond 64 are dropped and every result of
// that batch flags batch_overflow_o. Reset empties the chain, clears the job
// count and sets machine_count to one. machine_count is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is
// idle, which the block itself does not enforce.
`default_nettype none
module lpt_job_scheduler (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [lpt_pkg::MC_W-1:0]   cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [lpt_pkg::DUR_W-1:0]  duration_i,
  input  wire logic                       last_job_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [lpt_pkg::JOB_W-1:0]  job_number_o,
  output logic      [lpt_pkg::MACH_W-1:0] assigned_machine_o,
  output logic                            batch_overflow_o,
  output logic                            end_of_run_o
);
  localparam int N = lpt_pkg::MAX_JOBS;
  localparam int M = lpt_pkg::MAX_MACHINES;

  lpt_pkg::state_e state_q, state_d;
  logic [lpt_pkg::MC_W-1:0]   mc_q;
  logic [lpt_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       drop_q, drop_d;
  logic [lpt_pkg::K_W-1:0]    k_q, k_d;
  logic [lpt_pkg::MACH_W-1:0] best_q, best_d;
  logic [lpt_pkg::LOAD_W-1:0] bload_q, bload_d;
  logic [lpt_pkg::LOAD_W-1:0] loads_q [M];
  logic [lpt_pkg::LOAD_W-1:0] loads_d [M];
  logic [lpt_pkg::JOB_W-1:0]  rd_q, rd_d;
  logic [lpt_pkg::K_W-1:0]    mach;
  logic [lpt_pkg::LOAD_W-1:0] kload, new_load;
  logic                       in_acc, out_acc;
  lpt_pkg::chain_op_e         op;
  lpt_pkg::cell_t             new_item;
  lpt_pkg::cell_t             cells [N];
  logic                       firsts [N];
  logic                       ram_we;
  logic [lpt_pkg::MACH_W-1:0] ram_rdata;
  logic                       ov_d, oeor_d, ovalid_d;
  logic [lpt_pkg::JOB_W-1:0]  ojob_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != lpt_pkg::ST_LOAD);

  always_comb begin
    if (mc_q == '0) begin
      mach = lpt_pkg::K_W'(1);
    end else if (mc_q > lpt_pkg::MC_W'(M)) begin
      mach = lpt_pkg::K_W'(M);
    end else begin
      mach = mc_q;
    end
  end

  assign new_item.valid = 1'b1;
  assign new_item.dur   = duration_i;
  assign new_item.idx   = cnt_q[lpt_pkg::JOB_W-1:0];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      lpt_pkg::cell_t left_c, right_c;
      logic           left_f;
      if (g == 0) begin : g_head
        assign left_c = '0;
        assign left_f = 1'b0;
      end else begin : g_body
        assign left_c = cells[g-1];
        assign left_f = firsts[g-1];
      end
      if (g == N - 1) begin : g_tail
        assign right_c = '0;
      end else begin : g_mid
        assign right_c = cells[g+1];
      end
      lpt_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .op_i        (op),
        .new_i       (new_item),
        .left_i      (left_c),
        .left_first_i(left_f),
        .right_i     (right_c),
        .cur_o       (cells[g]),
        .first_o     (firsts[g])
      );
    end
  endgenerate

  assign kload    = loads_q[k_q[lpt_pkg::MACH_W-1:0]];
  assign new_load = bload_q + lpt_pkg::LOAD_W'(cells[0].dur);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    k_d      = k_q;
    best_d   = best_q;
    bload_d  = bload_q;
    loads_d  = loads_q;
    rd_d     = rd_q;
    op       = lpt_pkg::OP_HOLD;
    ram_we   = 1'b0;
    ovalid_d = out_valid_o && !out_acc;
    ojob_d   = job_number_o;
    ov_d     = batch_overflow_o;
    oeor_d   = end_of_run_o;
    case (state_q)
      lpt_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (cnt_q < lpt_pkg::CNT_W'(N)) begin
            op    = lpt_pkg::OP_INS;
            cnt_d = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (last_job_i) begin
            for (int m = 0; m < M; m++) begin
              loads_d[m] = '0;
            end
            k_d     = lpt_pkg::K_W'(1);
            best_d  = '0;
            bload_d = '0;
            state_d = lpt_pkg::ST_SCHED;
          end
        end
      end
      lpt_pkg::ST_SCHED: begin
        if (k_q < mach) begin
          if (kload < bload_q) begin
            best_d  = k_q[lpt_pkg::MACH_W-1:0];
            bload_d = kload;
          end
          k_d = k_q + 1'b1;
        end else begin
          loads_d[best_q] = new_load;
          ram_we  = 1'b1;
          op      = lpt_pkg::OP_SHIFT;
          k_d     = lpt_pkg::K_W'(1);
          best_d  = '0;
          bload_d = (best_q == '0) ? new_load : loads_q[0];
          if (!cells[1].valid) begin
            rd_d    = '0;
            state_d = lpt_pkg::ST_EMIT_RD;
          end
        end
      end
      lpt_pkg::ST_EMIT_RD: begin
        if (!out_valid_o || !out_stall_i) begin
          state_d = lpt_pkg::ST_EMIT_WT;
        end
      end
      lpt_pkg::ST_EMIT_WT: begin
        ovalid_d = 1'b1;
        ojob_d   = rd_q;
        ov_d     = drop_q;
        oeor_d   = (lpt_pkg::CNT_W'(rd_q) + 1'b1) == cnt_q;
        if (oeor_d) begin
          cnt_d   = '0;
          drop_d  = 1'b0;
          op      = lpt_pkg::OP_CLEAR;
          state_d = lpt_pkg::ST_LOAD;
        end else begin
          rd_d    = rd_q + 1'b1;
          state_d = lpt_pkg::ST_EMIT_RD;
        end
      end
      default: state_d = lpt_pkg::ST_LOAD;
    endcase
  end

  lpt_ram #(
    .WIDTH(lpt_pkg::MACH_W),
    .DEPTH(N)
  ) u_assign_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cells[0].idx),
    .wdata_i(best_q),
    .raddr_i(rd_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpt_pkg::ST_LOAD;
      mc_q        <= lpt_pkg::MC_W'(1);
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      out_valid_o <= ovalid_d;
      if (cfg_we_i) begin
        mc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q                <= k_d;
    best_q             <= best_d;
    bload_q            <= bload_d;
    loads_q            <= loads_d;
    rd_q               <= rd_d;
    job_number_o       <= ojob_d;
    batch_overflow_o   <= ov_d;
    end_of_run_o       <= oeor_d;
    if (state_q == lpt_pkg::ST_EMIT_WT) begin
      assigned_machine_o <= ram_rdata;
    end
  end
endmodule
`default_nettype wire

[sv/lpt_checker.sv]
// Port-level assertions of the LPT job scheduler and their bind.
`default_nettype none
module lpt_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       cfg_we_i,
  input wire logic [lpt_pkg::MC_W-1:0]   cfg_wdata_i,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic [lpt_pkg::DUR_W-1:0]  duration_i,
  input wire logic                       last_job_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [lpt_pkg::JOB_W-1:0]  job_number_o,
  input wire logic [lpt_pkg::MACH_W-1:0] assigned_machine_o,
  input wire logic                       batch_overflow_o,
  input wire logic                       end_of_run_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(job_number_o)
      && $stable(assigned_machine_o) && $stable(end_of_run_o))
    else $error("Stalled result changed.");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_job_i |=> in_stall_o)
    else $error("Input open right after the batch closed.");

  a_mid_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_run_o |-> in_stall_o)
    else $error("Input open while a batch is still being emitted.");

  a_no_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && end_of_run_o |=> !out_valid_o)
    else $error("Result appeared after the final one of a batch.");
endmodule

bind lpt_job_scheduler lpt_checker u_lpt_checker (.*);
`default_nettype wire
